[hw/rtl/gfl_pkg.sv]
// shared constants and helpers for the gf(2^m) log/antilog arithmetic unit
package gfl_pkg;

	localparam int FIELD_BITS = 8;
	localparam int EXP_BITS = 32;

	localparam logic [2:0] CMD_ADD = 3'd0;
	localparam logic [2:0] CMD_MUL = 3'd1;
	localparam logic [2:0] CMD_LOG = 3'd2;
	localparam logic [2:0] CMD_ALOG = 3'd3;
	localparam logic [2:0] CMD_INV = 3'd4;
	localparam logic [2:0] CMD_POW = 3'd5;

	localparam logic [1:0] ERR_OK = 2'd0;
	localparam logic [1:0] ERR_ZERO = 2'd1;
	localparam logic [1:0] ERR_NOT_PRIM = 2'd2;

	// primitive polynomial of degree m, used as the reset value
	function automatic logic [16:0] default_poly(input int m);
		logic [16:0] p;
		unique case (m)
			2: p = 17'h00007;
			3: p = 17'h0000B;
			4: p = 17'h00013;
			5: p = 17'h00025;
			6: p = 17'h00043;
			7: p = 17'h00089;
			8: p = 17'h0011D;
			9: p = 17'h00211;
			10: p = 17'h00409;
			11: p = 17'h00805;
			12: p = 17'h01053;
			13: p = 17'h0201B;
			14: p = 17'h04443;
			15: p = 17'h08003;
			16: p = 17'h1100B;
			default: p = 17'h0011D;
		endcase
		return p;
	endfunction

endpackage

[hw/rtl/gf2m_log_table_alu.sv]
// gf(2^m) arithmetic unit: add, multiply, log, antilog, inverse and power via tables
//
// Accepts one command per clock while in_stall is low and returns one result per command
// in order; stalls collapse bubbles stage by stage, so input keeps flowing while a
// finished result waits. The log and antilog tables live in two memories that are rebuilt
// from the field polynomial, one entry per cycle, 2^FIELD_BITS - 1 entries in all, after
// reset and after every polynomial write; during the rebuild in_stall is high and
// cfg_ready is low. A polynomial that is not primitive makes
// every command answer with result 0 and error 2 until a primitive one is written.
module gf2m_log_table_alu #(
	parameter int FIELD_BITS = gfl_pkg::FIELD_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [FIELD_BITS:0]                field_polynomial,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [2:0]                         command,
	input  logic [FIELD_BITS-1:0]              elem_a,
	input  logic [FIELD_BITS-1:0]              elem_b,
	input  logic signed [gfl_pkg::EXP_BITS-1:0] exponent,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [FIELD_BITS-1:0]              result,
	output logic [1:0]                         error
);

	localparam int M = FIELD_BITS;
	localparam int ORDER = (1 << FIELD_BITS) - 1;
	localparam logic [M-1:0] ORDER_V = {M{1'b1}};
	localparam logic [M-1:0] LAST_IDX = ORDER_V - 1'b1;
	localparam logic [M:0] TOP_BIT = {1'b1, {M{1'b0}}};
	localparam logic [16:0] POLY_FULL = gfl_pkg::default_poly(FIELD_BITS);
	localparam logic [M:0] RESET_POLY = POLY_FULL[M:0];
	localparam int DIGITS = (gfl_pkg::EXP_BITS + FIELD_BITS - 1) / FIELD_BITS;
	localparam int EXT_W = DIGITS * FIELD_BITS;
	localparam int SUM_W = FIELD_BITS + $clog2(DIGITS + 1);
	localparam int WRAP_SHIFT = gfl_pkg::EXP_BITS % FIELD_BITS;
	localparam logic [M-1:0] WRAP_CORR = ORDER_V - M'(1 << WRAP_SHIFT);
	localparam int FOLDS = 6;
	localparam int PROD_W = 2 * FIELD_BITS;

	// table rebuild
	logic [M:0]   poly_q;
	logic         build_q;
	logic [M-1:0] bidx_q;
	logic [M-1:0] cur_q;
	logic         early_q;
	logic         np_q;
	logic [M:0]   shifted;
	logic [M-1:0] cur_next;
	logic         last;

	logic [M-1:0] alog_mem [0:ORDER-1];
	logic [M-1:0] log_mem [0:(1 << FIELD_BITS)-1];

	// pipeline
	logic en1, en2, en3, en4, en5, take;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	logic [EXT_W-1:0] exp_ext;
	logic [SUM_W-1:0] esum;
	logic [SUM_W-1:0] fold;
	logic [M-1:0]     r_next;
	logic [M:0]       msum, msub;
	logic [M-1:0]     midx, iidx;
	logic [M:0]       psum, psub;
	logic [M-1:0]     pidx, aidx;
	logic [M-1:0]     res_next;
	logic [1:0]       err_next;

	logic [2:0]       cmd_s1, cmd_s2, cmd_s3, cmd_s4;
	logic [M-1:0]     a_s1, a_s2, a_s3, a_s4;
	logic [M-1:0]     b_s1, b_s2, b_s3, b_s4;
	logic             ezero_s1, ezero_s2, ezero_s3, ezero_s4;
	logic [M-1:0]     la_s1, la_s2, la_s3, la_s4;
	logic [M-1:0]     lb_s1;
	logic [SUM_W-1:0] esum_s1;
	logic [M-1:0]     r_s2, r_s3;
	logic [M-1:0]     midx_s2, midx_s3;
	logic [M-1:0]     iidx_s2, iidx_s3;
	logic [PROD_W-1:0] prod_s3;
	logic [M-1:0]     alog_s4;
	logic [M-1:0]     res_s5;
	logic [1:0]       err_s5;

	assign cfg_ready = !build_q;

	always_comb begin
		shifted = {cur_q, 1'b0};
		if (shifted[M]) begin
			shifted = shifted ^ (poly_q | TOP_BIT);
		end
		cur_next = shifted[M-1:0];
		last = (bidx_q == LAST_IDX);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q <= RESET_POLY;
			build_q <= 1'b1;
			bidx_q <= '0;
			cur_q <= M'(1);
			early_q <= 1'b0;
			np_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			poly_q <= field_polynomial;
			build_q <= 1'b1;
			bidx_q <= '0;
			cur_q <= M'(1);
			early_q <= 1'b0;
		end else if (build_q) begin
			bidx_q <= bidx_q + 1'b1;
			cur_q <= cur_next;
			if (cur_next == M'(1) && !last) begin
				early_q <= 1'b1;
			end
			if (last) begin
				build_q <= 1'b0;
				np_q <= early_q || (cur_next != M'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (build_q) begin
			alog_mem[bidx_q] <= cur_q;
			log_mem[cur_q] <= bidx_q;
		end
	end

	// stage enables, a stage loads when it is empty or the next one moves
	assign en5 = !vld_s5 || !out_stall;
	assign en4 = !vld_s4 || en5;
	assign en3 = !vld_s3 || en4;
	assign en2 = !vld_s2 || en3;
	assign en1 = !vld_s1 || en2;
	assign in_stall = build_q || !en1;
	assign take = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= take;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= vld_s2;
			if (en4) vld_s4 <= vld_s3;
			if (en5) vld_s5 <= vld_s4;
		end
	end

	// exponent digit sum, 2^m is 1 modulo the group order
	always_comb begin
		exp_ext = EXT_W'($unsigned(exponent));
		esum = '0;
		for (int k = 0; k < DIGITS; k++) begin
			esum = esum + SUM_W'(exp_ext[k*M +: M]);
		end
		if (exponent[gfl_pkg::EXP_BITS-1]) begin
			esum = esum + SUM_W'(WRAP_CORR);
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			cmd_s1 <= command;
			a_s1 <= elem_a;
			b_s1 <= elem_b;
			ezero_s1 <= (exponent == '0);
			esum_s1 <= esum;
			la_s1 <= log_mem[elem_a];
			lb_s1 <= log_mem[elem_b];
		end
	end

	always_comb begin
		fold = esum_s1;
		for (int k = 0; k < FOLDS; k++) begin
			fold = SUM_W'(fold[M-1:0]) + (fold >> M);
		end
		r_next = (fold == SUM_W'(ORDER_V)) ? '0 : fold[M-1:0];
		msum = {1'b0, la_s1} + {1'b0, lb_s1};
		msub = msum - {1'b0, ORDER_V};
		midx = (msum >= {1'b0, ORDER_V}) ? msub[M-1:0] : msum[M-1:0];
		iidx = (la_s1 == '0) ? '0 : ORDER_V - la_s1;
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			cmd_s2 <= cmd_s1;
			a_s2 <= a_s1;
			b_s2 <= b_s1;
			ezero_s2 <= ezero_s1;
			la_s2 <= la_s1;
			r_s2 <= r_next;
			midx_s2 <= midx;
			iidx_s2 <= iidx;
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			cmd_s3 <= cmd_s2;
			a_s3 <= a_s2;
			b_s3 <= b_s2;
			ezero_s3 <= ezero_s2;
			la_s3 <= la_s2;
			r_s3 <= r_s2;
			midx_s3 <= midx_s2;
			iidx_s3 <= iidx_s2;
			prod_s3 <= PROD_W'(la_s2) * PROD_W'(r_s2);
		end
	end

	always_comb begin
		psum = {1'b0, prod_s3[M-1:0]} + {1'b0, prod_s3[PROD_W-1:M]};
		psub = psum - {1'b0, ORDER_V};
		pidx = (psum >= {1'b0, ORDER_V}) ? psub[M-1:0] : psum[M-1:0];
		unique case (cmd_s3)
			gfl_pkg::CMD_MUL: aidx = midx_s3;
			gfl_pkg::CMD_ALOG: aidx = r_s3;
			gfl_pkg::CMD_INV: aidx = iidx_s3;
			gfl_pkg::CMD_POW: aidx = pidx;
			default: aidx = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			cmd_s4 <= cmd_s3;
			a_s4 <= a_s3;
			b_s4 <= b_s3;
			ezero_s4 <= ezero_s3;
			la_s4 <= la_s3;
			alog_s4 <= alog_mem[aidx];
		end
	end

	always_comb begin
		res_next = '0;
		err_next = gfl_pkg::ERR_OK;
		if (np_q) begin
			err_next = gfl_pkg::ERR_NOT_PRIM;
		end else begin
			unique case (cmd_s4)
				gfl_pkg::CMD_ADD: res_next = a_s4 ^ b_s4;
				gfl_pkg::CMD_MUL: res_next = (a_s4 != '0 && b_s4 != '0) ? alog_s4 : '0;
				gfl_pkg::CMD_LOG: begin
					if (a_s4 == '0) err_next = gfl_pkg::ERR_ZERO;
					else res_next = la_s4;
				end
				gfl_pkg::CMD_ALOG: res_next = alog_s4;
				gfl_pkg::CMD_INV: begin
					if (a_s4 == '0) err_next = gfl_pkg::ERR_ZERO;
					else res_next = alog_s4;
				end
				gfl_pkg::CMD_POW: begin
					if (a_s4 == '0) res_next = ezero_s4 ? M'(1) : '0;
					else res_next = alog_s4;
				end
				default: res_next = '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			res_s5 <= res_next;
			err_s5 <= err_next;
		end
	end

	assign out_valid = vld_s5;
	assign result = res_s5;
	assign error = err_s5;

endmodule

[hw/rtl/gfl_alu_checker.sv]
// port-level checks for the gf(2^m) arithmetic unit, bound to the top level
module gfl_alu_checker #(
	parameter int FIELD_BITS = gfl_pkg::FIELD_BITS
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  cfg_valid,
	input logic                  cfg_ready,
	input logic                  in_stall,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic [FIELD_BITS-1:0] result,
	input logic [1:0]            error
);

	// no input transfer while the tables are rebuilt
	a_build_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_ready |-> in_stall)
		else $error("input open during table rebuild");

	// a polynomial write starts a rebuild
	a_cfg_starts_build: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> !cfg_ready && in_stall)
		else $error("no rebuild after polynomial transfer");

	// any error code comes with a zero result
	a_error_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error != gfl_pkg::ERR_OK |-> result == '0)
		else $error("nonzero result with error");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result) && $stable(error))
		else $error("stalled result changed");

endmodule

bind gf2m_log_table_alu gfl_alu_checker #(.FIELD_BITS(FIELD_BITS)) u_gfl_alu_checker (.*);

[bench/gf_answer_checker.sv]
// answer checker for the gf(2^m) log/antilog unit: own tables, prediction and comparison
`timescale 1ns / 1ps
module gf_answer_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic                                cfg_ready,
	input  logic [gfl_pkg::FIELD_BITS:0]        field_polynomial,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic [2:0]                          command,
	input  logic [gfl_pkg::FIELD_BITS-1:0]      elem_a,
	input  logic [gfl_pkg::FIELD_BITS-1:0]      elem_b,
	input  logic signed [gfl_pkg::EXP_BITS-1:0] exponent,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic [gfl_pkg::FIELD_BITS-1:0]      result,
	input  logic [1:0]                          error,
	output int                                  fail_count,
	output int                                  pending,
	output int                                  answers_checked,
	output int                                  tables_built,
	output int                                  nonprim_builds
);
	import gfl_pkg::*;

	localparam int M = FIELD_BITS;
	localparam int ORDER = (1 << M) - 1;
	localparam logic [M:0] POLY_RESET = 'h11D;

	typedef struct packed {
		logic [2:0]          cmd;
		logic [M-1:0]        a;
		logic [M-1:0]        b;
		logic [EXP_BITS-1:0] e;
		logic [M-1:0]        res;
		logic [1:0]          err;
	} answer_t;

	logic [M:0]   poly_reg;
	logic [M-1:0] alpha_pow [0:ORDER-1];
	logic [M-1:0] alpha_log [0:ORDER];
	bit           non_primitive;
	answer_t      pending_answers [$];
	answer_t      want;

	// walk x^i through the field, recording both directions
	function automatic void rebuild_tables();
		logic [M:0] taps;
		logic [M:0] cur;
		bit         early;
		taps = poly_reg;
		taps[M] = 1'b1;
		cur = 1;
		early = 1'b0;
		for (int i = 0; i < ORDER; i++) begin
			alpha_pow[i] = cur[M-1:0];
			alpha_log[cur[M-1:0]] = M'(i);
			cur = cur << 1;
			if (cur[M])
				cur ^= taps;
			if (cur == 1 && i != ORDER - 1)
				early = 1'b1;
		end
		alpha_log[0] = '0;
		non_primitive = early || cur != 1;
	endfunction

	// non-negative remainder of a signed exponent by the group order
	function automatic int exp_mod_order(input logic signed [EXP_BITS-1:0] e);
		longint v;
		v = e;
		v = v % ORDER;
		if (v < 0)
			v += ORDER;
		return int'(v);
	endfunction

	function automatic answer_t field_answer(input logic [2:0] cmd, input logic [M-1:0] a,
			input logic [M-1:0] b, input logic signed [EXP_BITS-1:0] e);
		answer_t x;
		x.cmd = cmd;
		x.a = a;
		x.b = b;
		x.e = e;
		x.res = '0;
		x.err = ERR_OK;
		if (non_primitive) begin
			x.err = ERR_NOT_PRIM;
		end else begin
			case (cmd)
				CMD_ADD: x.res = a ^ b;
				CMD_MUL: begin
					if (a != 0 && b != 0)
						x.res = alpha_pow[(int'(alpha_log[a]) + int'(alpha_log[b])) % ORDER];
				end
				CMD_LOG: begin
					if (a == 0)
						x.err = ERR_ZERO;
					else
						x.res = alpha_log[a];
				end
				CMD_ALOG: x.res = alpha_pow[exp_mod_order(e)];
				CMD_INV: begin
					if (a == 0)
						x.err = ERR_ZERO;
					else
						x.res = alpha_pow[(ORDER - int'(alpha_log[a])) % ORDER];
				end
				CMD_POW: begin
					if (a == 0)
						x.res = (e == 0) ? M'(1) : '0;
					else
						x.res = alpha_pow[(int'(alpha_log[a]) * exp_mod_order(e)) % ORDER];
				end
				default: ;
			endcase
		end
		return x;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_reg = POLY_RESET;
			rebuild_tables();
			pending_answers.delete();
			fail_count = 0;
			answers_checked = 0;
			tables_built = 1;
			nonprim_builds = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				poly_reg = field_polynomial;
				rebuild_tables();
				tables_built++;
				if (non_primitive)
					nonprim_builds++;
			end
			if (in_valid && !in_stall)
				pending_answers.push_back(field_answer(command, elem_a, elem_b, exponent));
			if (out_valid && !out_stall) begin
				answers_checked++;
				if (pending_answers.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: unexpected transfer, result %0d error %0d",
							$time, result, error);
				end else begin
					want = pending_answers.pop_front();
					if (result !== want.res || error !== want.err) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"%0t: cmd %0d a %0d b %0d exp %0d: ",
								"result %0d want %0d, error %0d want %0d"},
								$time, want.cmd, want.a, want.b, $signed(want.e),
								result, want.res, error, want.err);
					end
				end
			end
		end
		pending = pending_answers.size();
	end

endmodule

[bench/testbench.sv]
// top of the gf(2^m) log/antilog unit bench: clock, reset, traffic, polynomial phases, verdict
`timescale 1ns / 1ps
module testbench;
	import gfl_pkg::*;

	localparam int M = FIELD_BITS;
	localparam logic [2:0] CMD_SPARE_LO = 3'd6;
	localparam logic [2:0] CMD_SPARE_HI = 3'd7;
	localparam logic [M:0] POLY_RESET = 'h11D;
	localparam int PHASES = 11;
	localparam int ITEMS_PER_PHASE = 80;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [M:0]                 field_polynomial;
	logic                       in_valid;
	logic                       in_stall;
	logic [2:0]                 command;
	logic [M-1:0]               elem_a;
	logic [M-1:0]               elem_b;
	logic signed [EXP_BITS-1:0] exponent;
	logic                       out_valid;
	logic                       out_stall;
	logic [M-1:0]               result;
	logic [1:0]                 error;

	int fail_count;
	int pending;
	int answers_checked;
	int tables_built;
	int nonprim_builds;
	int burst_left = 0;
	int stall_mode = 0;
	int stall_run = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	gf2m_log_table_alu u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.field_polynomial (field_polynomial),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.command          (command),
		.elem_a           (elem_a),
		.elem_b           (elem_b),
		.exponent         (exponent),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.result           (result),
		.error            (error)
	);

	gf_answer_checker u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.field_polynomial (field_polynomial),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.command          (command),
		.elem_a           (elem_a),
		.elem_b           (elem_b),
		.exponent         (exponent),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.result           (result),
		.error            (error),
		.fail_count       (fail_count),
		.pending          (pending),
		.answers_checked  (answers_checked),
		.tables_built     (tables_built),
		.nonprim_builds   (nonprim_builds)
	);

	// receiver: free, light, heavy or periodic stalling, with the mode picked at random after each run
	always @(negedge clk) begin
		if (stall_run == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_run = $urandom_range(20, 150);
		end else begin
			stall_run--;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 2) == 0);
			2: out_stall <= ($urandom_range(0, 3) != 0);
			default: out_stall <= ((stall_run % 16) < 11);
		endcase
	end

	task automatic send_item(input logic [2:0] cmd, input logic [M-1:0] a,
			input logic [M-1:0] b, input logic [EXP_BITS-1:0] e);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		command <= cmd;
		elem_a <= a;
		elem_b <= b;
		exponent <= e;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		burst_left = 0;
	endtask

	task automatic write_polynomial(input logic [M:0] p);
		drain_results();
		repeat (8) @(negedge clk);
		cfg_valid <= 1'b1;
		field_polynomial <= p;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [M-1:0] pick_element();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return M'(1);
			2: return '1;
			default: return M'($urandom);
		endcase
	endfunction

	function automatic logic [EXP_BITS-1:0] pick_exponent();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return 32'h8000_0000;
			2: return 32'h7FFF_FFFF;
			3: return 32'(255 * (int'($urandom_range(0, 2000)) - 1000));
			4, 5: return 32'(int'($urandom_range(0, 1200)) - 600);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [M:0] phase_polynomial(input int k);
		case (k)
			1: return 'h11B;
			2: return 'h12B;
			3: return 'h100;
			4: return 'h1FF;
			5: return 'h01D;
			6: return 'h14D;
			7: return 'h1F5;
			8: begin
				case ($urandom_range(0, 5))
					0: return 'h12D;
					1: return 'h15F;
					2: return 'h169;
					3: return 'h187;
					4: return 'h1C3;
					default: return 'h1E7;
				endcase
			end
			9: return (M+1)'($urandom);
			default: return POLY_RESET;
		endcase
	endfunction

	task automatic send_random_item();
		logic [2:0] cmd;
		if ($urandom_range(0, 99) < 3)
			cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
		else
			cmd = 3'($urandom_range(CMD_ADD, CMD_POW));
		send_item(cmd, pick_element(), pick_element(), pick_exponent());
	endtask

	initial begin
		#3_000_000;
		$display("timeout, %0d transfers still outstanding", pending);
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		field_polynomial = POLY_RESET;
		in_valid = 1'b0;
		command = CMD_ADD;
		elem_a = '0;
		elem_b = '0;
		exponent = '0;
		out_stall = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_item(CMD_ADD, 8'h00, 8'h00, '0);
		send_item(CMD_ADD, 8'hFF, 8'hFF, '0);
		send_item(CMD_ADD, 8'hAA, 8'h55, '0);
		send_item(CMD_MUL, 8'h00, 8'h37, '0);
		send_item(CMD_MUL, 8'h9C, 8'h00, '0);
		send_item(CMD_MUL, 8'hFF, 8'hFF, '0);
		send_item(CMD_MUL, 8'h01, 8'hC5, '0);
		send_item(CMD_LOG, 8'h00, 8'h00, '0);
		send_item(CMD_LOG, 8'h01, 8'h00, '0);
		send_item(CMD_LOG, 8'hFF, 8'h00, '0);
		send_item(CMD_ALOG, 8'h00, 8'h00, '0);
		send_item(CMD_ALOG, 8'h00, 8'h00, 32'hFFFF_FFFF);
		send_item(CMD_ALOG, 8'h00, 8'h00, 32'd255);
		send_item(CMD_ALOG, 8'h00, 8'h00, 32'(-255));
		send_item(CMD_ALOG, 8'h00, 8'h00, 32'h8000_0000);
		send_item(CMD_ALOG, 8'h00, 8'h00, 32'h7FFF_FFFF);
		send_item(CMD_INV, 8'h00, 8'h00, '0);
		send_item(CMD_INV, 8'h01, 8'h00, '0);
		send_item(CMD_INV, 8'hFF, 8'h00, '0);
		send_item(CMD_POW, 8'h00, 8'h00, '0);
		send_item(CMD_POW, 8'h00, 8'h00, 32'(-3));
		send_item(CMD_POW, 8'h02, 8'h00, 32'h8000_0000);
		send_item(CMD_POW, 8'hFF, 8'h00, 32'h7FFF_FFFF);
		send_item(CMD_POW, 8'h03, 8'h00, 32'hFFFF_FFFF);
		send_item(CMD_SPARE_LO, 8'h5A, 8'hA5, 32'd7);
		send_item(CMD_SPARE_HI, 8'hFF, 8'hFF, 32'hFFFF_FFFF);

		for (int k = 0; k < PHASES; k++) begin
			if (k != 0)
				write_polynomial(phase_polynomial(k));
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				send_random_item();
				if (k == 2 && n == ITEMS_PER_PHASE / 2)
					drain_results();
			end
		end

		drain_results();
		repeat (10) @(negedge clk);
		$display("%0d answers compared over %0d table builds (%0d with a non-primitive polynomial)",
			answers_checked, tables_built, nonprim_builds);
		if (fail_count == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
